// ----- rtl/qsa_pkg.sv -----
// Shared constants and the lane type handed along the divider cell chain of the Q16.16 ALU.
package qsa_pkg;
  localparam int FRACTION_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DIV_STEPS = WORD_BITS + FRACTION_BITS;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_SINT = 3'd4;
  localparam logic [2:0] OP_UINT = 3'd5;

  localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic        vld;
    logic [2:0]  op;
    logic        neg;
    logic        dzero;
    logic        aneg;
    logic [31:0] fast;
    logic [32:0] rem;
    logic [31:0] dvd;
    logic [32:0] dvs;
    logic [47:0] quo;
  } qsa_lane_t;
endpackage

// ----- rtl/qsa_cell.sv -----
// One restoring divide step per cell; a non-divide result rides along unchanged.
module qsa_cell
  import qsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qsa_lane_t lane_in,
  output qsa_lane_t lane_out
);
  qsa_lane_t lane_r, lane_nxt;
  logic [33:0] trial;

  always_comb begin
    lane_nxt = lane_in;
    trial = {lane_in.rem, lane_in.dvd[31]};
    lane_nxt.dvd = {lane_in.dvd[30:0], 1'b0};
    if (trial >= {1'b0, lane_in.dvs}) begin
      lane_nxt.rem = 33'(trial - {1'b0, lane_in.dvs});
      lane_nxt.quo = {lane_in.quo[46:0], 1'b1};
    end else begin
      lane_nxt.rem = trial[32:0];
      lane_nxt.quo = {lane_in.quo[46:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
    lane_r.op    <= lane_nxt.op;
    lane_r.neg   <= lane_nxt.neg;
    lane_r.dzero <= lane_nxt.dzero;
    lane_r.aneg  <= lane_nxt.aneg;
    lane_r.fast  <= lane_nxt.fast;
    lane_r.rem   <= lane_nxt.rem;
    lane_r.dvd   <= lane_nxt.dvd;
    lane_r.dvs   <= lane_nxt.dvs;
    lane_r.quo   <= lane_nxt.quo;
  end

  assign lane_out = lane_r;
endmodule

// ----- rtl/qsa_front.sv -----
// Input stage: add, subtract, multiply and conversions, divide operand setup.
module qsa_front
  import qsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req,
  input  logic [2:0]         op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [32:0] iv,
  output qsa_lane_t          lane_out
);
  logic vld_r;
  logic [2:0] op_r;
  logic signed [31:0] a_r, b_r;
  logic signed [32:0] iv_r;
  logic [31:0] am, bm;
  logic [47:0] hh_r, hl_r, lh_r, ll_r;
  logic [31:0] mag_r, ln_r;
  logic an_r, bn_r;
  logic neg;
  logic [32:0] sum, dif;
  logic [31:0] lim, fast;
  logic [49:0] acc;
  qsa_lane_t lane_r, lane_nxt;

  assign am = a[31] ? 32'(-a) : a;
  assign bm = b[31] ? 32'(-b) : b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req;
    end
    op_r <= op;
    a_r  <= a;
    b_r  <= b;
    iv_r <= iv;
    an_r <= a[31];
    bn_r <= b[31];
    hh_r <= 48'(am[31:16] * bm[31:16]);
    hl_r <= 48'(am[31:16] * bm[15:0]);
    lh_r <= 48'(am[15:0] * bm[31:16]);
    ll_r <= 48'(am[15:0] * bm[15:0]);
    mag_r <= am;
    ln_r  <= bm;
  end

  always_comb begin
    neg = an_r ^ bn_r;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    sum = 33'({a_r[31], a_r} + {b_r[31], b_r});
    dif = 33'({a_r[31], a_r} - {b_r[31], b_r});
    acc = 50'({hh_r[33:0], 16'd0}) + 50'(hl_r) + 50'(lh_r) + 50'(ll_r[47:16]);
    fast = 32'd0;
    case (op_r)
      OP_ADD: fast = (sum[32] != sum[31]) ? (sum[32] ? NEG_LIMIT : POS_LIMIT) : sum[31:0];
      OP_SUB: fast = (dif[32] != dif[31]) ? (dif[32] ? NEG_LIMIT : POS_LIMIT) : dif[31:0];
      OP_MUL: begin
        if (acc >= 50'(lim)) fast = neg ? NEG_LIMIT : POS_LIMIT;
        else fast = neg ? 32'(-acc[31:0]) : acc[31:0];
      end
      OP_SINT: begin
        if ($signed(iv_r) > 33'sd32767) fast = POS_LIMIT;
        else if ($signed(iv_r) < -33'sd32768) fast = NEG_LIMIT;
        else fast = {iv_r[15:0], 16'd0};
      end
      OP_UINT: fast = (iv_r > 33'd32767) ? POS_LIMIT : {iv_r[15:0], 16'd0};
      default: fast = 32'd0;
    endcase
    lane_nxt.vld   = vld_r;
    lane_nxt.op    = op_r;
    lane_nxt.neg   = neg;
    lane_nxt.dzero = (ln_r == 32'd0);
    lane_nxt.aneg  = an_r;
    lane_nxt.fast  = fast;
    lane_nxt.rem   = 33'd0;
    lane_nxt.dvd   = mag_r;
    lane_nxt.dvs   = {1'b0, ln_r};
    lane_nxt.quo   = 48'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
    lane_r.op    <= lane_nxt.op;
    lane_r.neg   <= lane_nxt.neg;
    lane_r.dzero <= lane_nxt.dzero;
    lane_r.aneg  <= lane_nxt.aneg;
    lane_r.fast  <= lane_nxt.fast;
    lane_r.rem   <= lane_nxt.rem;
    lane_r.dvd   <= lane_nxt.dvd;
    lane_r.dvs   <= lane_nxt.dvs;
    lane_r.quo   <= lane_nxt.quo;
  end

  assign lane_out = lane_r;
endmodule

// ----- rtl/q16_saturating_alu.sv -----
// Q16.16 saturating ALU: front stage, a chain of 48 divide cells and an output register.
// Every operation takes the same path from start to out_valid.
// Throughput: one request per cycle; busy is always low.
// The chain of one-bit restoring divide cells sets the latency.
// Reset (synchronous, rst_n low) clears all valid flags; data registers are not reset.
// The receiver cannot stall: each result is shown for one cycle with out_valid.
module q16_saturating_alu
  import qsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_left_operand,
  input  logic signed [31:0] in_right_operand,
  input  logic signed [32:0] in_integer_value,
  output logic               out_valid,
  output logic signed [31:0] out_fixed_result
);
  qsa_lane_t chain [DIV_STEPS+1];
  qsa_lane_t last;
  logic [31:0] res_nxt, res_r;
  logic vld_r;
  logic [47:0] q;
  logic [31:0] lim;

  assign busy = 1'b0;

  qsa_front u_front (
    .clk(clk), .rst_n(rst_n), .req(start & ~busy), .op(in_operation),
    .a(in_left_operand), .b(in_right_operand), .iv(in_integer_value),
    .lane_out(chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    qsa_cell u_cell (.clk(clk), .rst_n(rst_n), .lane_in(chain[i]), .lane_out(chain[i+1]));
  end

  assign last = chain[DIV_STEPS];
  assign q = last.quo;
  assign lim = last.neg ? NEG_LIMIT : POS_LIMIT;

  always_comb begin
    res_nxt = last.fast;
    if (last.op == OP_DIV) begin
      if (last.dzero) res_nxt = last.aneg ? NEG_LIMIT : POS_LIMIT;
      else if (q >= 48'(lim)) res_nxt = last.neg ? NEG_LIMIT : POS_LIMIT;
      else res_nxt = last.neg ? 32'(-q[31:0]) : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= last.vld;
    end
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_fixed_result = res_r;

`ifndef SYNTHESIS
  a_no_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    last.vld |=> out_valid) else $error("lost request");
  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 chain[0].vld) else $error("front stage lost request");
`endif
endmodule
